// ----- hdl/frix_pkg.sv -----
// ----------------------------------------------------------------------------
// frix_pkg
// Shared types, codes and helper functions of the FASTA record index scanner.
// ----------------------------------------------------------------------------
package frix_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_BENCH   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // Alphabet codes of a record.
  localparam logic [1:0] ALPHA_DNA     = 2'd0;
  localparam logic [1:0] ALPHA_RNA     = 2'd1;
  localparam logic [1:0] ALPHA_PROTEIN = 2'd2;

  // Forced alphabet register values.
  localparam logic [1:0] FORCE_DETECT = 2'd0;

  // Input commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  // Register map: index is byte address divided by four.
  localparam int unsigned REG_ADDR_BITS = 3;
  localparam logic REG_BENCH_INTERVAL  = 1'b0;
  localparam logic REG_FORCED_ALPHABET = 1'b1;
  localparam logic [31:0] BENCH_INTERVAL_RESET = 32'd1000;

  // Characters of interest.
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // Letters A, C, G, N, T and U as bits of the seen-letter set.
  localparam int unsigned LETTER_COUNT = 26;
  localparam logic [LETTER_COUNT-1:0] NUC_LETTERS = 26'h0182045;
  localparam int unsigned LETTER_U = 20;

  // Result queue depth; an end-of-file item can push two results at once.
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic [31:0] bench_interval;
    logic [1:0]  forced_alphabet;
  } cfg_t;

  // One result item without its offset, whose width is a parameter.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq_number;
    logic [31:0] record_length;
    logic [15:0] name_length;
    logic [1:0]  alphabet;
    logic [31:0] benchmark_count;
    logic [2:0]  alphabet_flags;
    logic        last;
  } result_t;

  function automatic logic is_run_byte(input logic [7:0] b);
    return (b > CHAR_SPACE) && !b[7];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  function automatic logic [1:0] record_alphabet(input logic [LETTER_COUNT-1:0] letters,
                                                 input logic [1:0] forced);
    logic [1:0] a;
    if (forced != FORCE_DETECT) begin
      a = forced - 2'd1;
    end else if ((letters & ~NUC_LETTERS) == '0) begin
      a = letters[LETTER_U] ? ALPHA_RNA : ALPHA_DNA;
    end else begin
      a = ALPHA_PROTEIN;
    end
    return a;
  endfunction

  function automatic logic [2:0] alphabet_flag(input logic [1:0] a);
    logic [2:0] f;
    unique case (a)
      ALPHA_DNA:     f = 3'b001;
      ALPHA_RNA:     f = 3'b010;
      ALPHA_PROTEIN: f = 3'b100;
      default:       f = 3'b000;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/frix_channels.sv -----
// ----------------------------------------------------------------------------
// frix channels
// Valid/ready channels of the scanner: file bytes in, index events out.
// ----------------------------------------------------------------------------
interface frix_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source(output valid, output cmd, output data_byte, input ready);
  modport sink(input valid, input cmd, input data_byte, output ready);
endinterface

interface frix_out_if #(
  parameter int unsigned OFFSET_BITS = 48
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [31:0]            seq_number;
  logic [OFFSET_BITS-1:0] offset;
  logic [31:0]            record_length;
  logic [15:0]            name_length;
  logic [1:0]             alphabet;
  logic [31:0]            benchmark_count;
  logic [2:0]             alphabet_flags;
  logic                   last;

  modport source(output valid, output kind, output seq_number, output offset,
                 output record_length, output name_length, output alphabet,
                 output benchmark_count, output alphabet_flags, output last,
                 input ready);
  modport sink(input valid, input kind, input seq_number, input offset,
               input record_length, input name_length, input alphabet,
               input benchmark_count, input alphabet_flags, input last,
               output ready);
endinterface

// ----- hdl/frix_cfg.sv -----
// ----------------------------------------------------------------------------
// frix_cfg
// APB register file: benchmark interval and forced alphabet.
// ----------------------------------------------------------------------------
module frix_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [frix_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output frix_pkg::cfg_t                     cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bench_interval  <= frix_pkg::BENCH_INTERVAL_RESET;
      cfg.forced_alphabet <= frix_pkg::FORCE_DETECT;
    end else if (wr_en) begin
      unique case (reg_index)
        frix_pkg::REG_BENCH_INTERVAL:  cfg.bench_interval  <= pwdata;
        frix_pkg::REG_FORCED_ALPHABET: cfg.forced_alphabet <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Byte lanes below bit 2 do not select a register.
  always_comb begin
    prdata = {30'd0, paddr[1:0]} & 32'd0;
    unique case (reg_index)
      frix_pkg::REG_BENCH_INTERVAL:  prdata = cfg.bench_interval;
      frix_pkg::REG_FORCED_ALPHABET: prdata = {30'd0, cfg.forced_alphabet};
      default: ;
    endcase
  end

endmodule

// ----- hdl/frix_core.sv -----
// ----------------------------------------------------------------------------
// frix_core
// Input register and per-byte scan logic; produces up to two results per item.
// ----------------------------------------------------------------------------
module frix_core #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [7:0]             in_byte,
  input  frix_pkg::cfg_t         cfg,
  input  logic                   rq_room,
  output logic                   push0,
  output logic                   push1,
  output frix_pkg::result_t      res0,
  output frix_pkg::result_t      res1,
  output logic [OFFSET_BITS-1:0] off0,
  output logic [OFFSET_BITS-1:0] off1
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam int unsigned NL = frix_pkg::LETTER_COUNT;

  // Input register.
  logic       item_valid;
  logic       item_cmd;
  logic [7:0] item_byte;
  logic       fire;

  // Scan state.
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic        at_line_start, at_line_start_next;
  logic        in_header, in_header_next;
  logic        name_run_open, name_run_open_next;
  logic        residue_run_open, residue_run_open_next;
  logic [31:0] residues_counted, residues_counted_next;
  logic [31:0] data_distance, data_distance_next;
  logic [31:0] bench_countdown, bench_countdown_next;
  logic [31:0] bench_total, bench_total_next;
  logic [NL-1:0] letters_seen, letters_seen_next;
  logic [31:0] record_total, record_total_next;
  logic [15:0] longest_name, longest_name_next;
  logic [15:0] current_name_len, current_name_len_next;
  logic [2:0]  alphabets_present, alphabets_present_next;

  // Helpers.
  logic [OFFSET_BITS-1:0] pos_inc;
  logic        has_record;
  logic [1:0]  rec_alpha;
  logic [2:0]  rec_flag;
  logic [31:0] dist_inc;
  logic [31:0] countdown_dec;
  logic [15:0] name_inc;
  logic        run_byte;
  logic        run_open_eff;
  logic        is_upper, is_lower;
  logic [7:0]  letter_diff;
  logic [NL-1:0] letter_bit;

  assign fire     = item_valid && rq_room;
  assign in_ready = !item_valid || rq_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd  <= in_cmd;
      item_byte <= in_byte;
    end
  end

  assign pos_inc       = (byte_position != POS_MAX) ? byte_position + 1'b1 : byte_position;
  assign has_record    = (record_total != 32'd0);
  assign rec_alpha     = frix_pkg::record_alphabet(letters_seen, cfg.forced_alphabet);
  assign rec_flag      = frix_pkg::alphabet_flag(rec_alpha);
  assign dist_inc      = frix_pkg::sat_inc32(data_distance);
  assign countdown_dec = bench_countdown - 32'd1;
  assign name_inc      = frix_pkg::sat_inc16(current_name_len);
  assign run_byte      = frix_pkg::is_run_byte(item_byte);
  assign run_open_eff  = at_line_start || residue_run_open;
  assign is_upper      = (item_byte >= frix_pkg::CHAR_UPPER_A) &&
                         (item_byte <= frix_pkg::CHAR_UPPER_Z);
  assign is_lower      = (item_byte >= frix_pkg::CHAR_LOWER_A) &&
                         (item_byte <= frix_pkg::CHAR_LOWER_Z);
  assign letter_diff   = is_upper ? item_byte - frix_pkg::CHAR_UPPER_A
                                  : item_byte - frix_pkg::CHAR_LOWER_A;
  assign letter_bit    = (is_upper || is_lower) ? NL'(1) << letter_diff[4:0] : '0;

  always_comb begin
    byte_position_next     = byte_position;
    at_line_start_next     = at_line_start;
    in_header_next         = in_header;
    name_run_open_next     = name_run_open;
    residue_run_open_next  = residue_run_open;
    residues_counted_next  = residues_counted;
    data_distance_next     = data_distance;
    bench_countdown_next   = bench_countdown;
    bench_total_next       = bench_total;
    letters_seen_next      = letters_seen;
    record_total_next      = record_total;
    longest_name_next      = longest_name;
    current_name_len_next  = current_name_len;
    alphabets_present_next = alphabets_present;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = '0;
    res1  = '0;
    off0  = '0;
    off1  = '0;

    if (fire) begin
      if (item_cmd == frix_pkg::CMD_EOF) begin
        // An open header line still gets its record-start event first.
        if (in_header) begin
          push0            = 1'b1;
          res0.kind        = frix_pkg::KIND_START;
          res0.seq_number  = record_total - 32'd1;
          res0.name_length = current_name_len;
          off0             = byte_position;
          push1                = 1'b1;
          res1.kind            = frix_pkg::KIND_SUMMARY;
          res1.seq_number      = record_total;
          res1.record_length   = has_record ? residues_counted : 32'd0;
          res1.name_length     = longest_name;
          res1.alphabet        = has_record ? rec_alpha : frix_pkg::ALPHA_DNA;
          res1.benchmark_count = has_record ? bench_total : 32'd0;
          res1.alphabet_flags  = alphabets_present | (has_record ? rec_flag : 3'b000);
          res1.last            = 1'b1;
          off1                 = byte_position;
        end else begin
          push0                = 1'b1;
          res0.kind            = frix_pkg::KIND_SUMMARY;
          res0.seq_number      = record_total;
          res0.record_length   = has_record ? residues_counted : 32'd0;
          res0.name_length     = longest_name;
          res0.alphabet        = has_record ? rec_alpha : frix_pkg::ALPHA_DNA;
          res0.benchmark_count = has_record ? bench_total : 32'd0;
          res0.alphabet_flags  = alphabets_present | (has_record ? rec_flag : 3'b000);
          res0.last            = 1'b1;
          off0                 = byte_position;
        end
        // The next byte starts a new file.
        byte_position_next     = '0;
        at_line_start_next     = 1'b1;
        in_header_next         = 1'b0;
        name_run_open_next     = 1'b0;
        residue_run_open_next  = 1'b0;
        residues_counted_next  = '0;
        data_distance_next     = '0;
        bench_countdown_next   = '0;
        bench_total_next       = '0;
        letters_seen_next      = '0;
        record_total_next      = '0;
        longest_name_next      = '0;
        current_name_len_next  = '0;
        alphabets_present_next = '0;
      end else begin
        byte_position_next = pos_inc;
        if (at_line_start && (item_byte == frix_pkg::CHAR_GT)) begin
          if (has_record) begin
            push0                  = 1'b1;
            res0.kind              = frix_pkg::KIND_END;
            res0.seq_number        = record_total - 32'd1;
            res0.record_length     = residues_counted;
            res0.alphabet          = rec_alpha;
            res0.benchmark_count   = bench_total;
            res0.last              = 1'b1;
            alphabets_present_next = alphabets_present | rec_flag;
          end
          record_total_next     = frix_pkg::sat_inc32(record_total);
          in_header_next        = 1'b1;
          name_run_open_next    = 1'b1;
          current_name_len_next = '0;
          residues_counted_next = '0;
          data_distance_next    = '0;
          bench_countdown_next  = cfg.bench_interval;
          bench_total_next      = '0;
          letters_seen_next     = '0;
          at_line_start_next    = 1'b0;
        end else if (in_header) begin
          if (item_byte == frix_pkg::CHAR_LF) begin
            in_header_next     = 1'b0;
            at_line_start_next = 1'b1;
            push0              = 1'b1;
            res0.kind          = frix_pkg::KIND_START;
            res0.seq_number    = record_total - 32'd1;
            res0.name_length   = current_name_len;
            res0.last          = 1'b1;
            off0               = pos_inc;
          end else begin
            if (name_run_open && run_byte) begin
              current_name_len_next = name_inc;
              if (name_inc > longest_name) begin
                longest_name_next = name_inc;
              end
            end else begin
              name_run_open_next = 1'b0;
            end
            at_line_start_next = 1'b0;
          end
        end else if (has_record) begin
          at_line_start_next = 1'b0;
          data_distance_next = dist_inc;
          if (item_byte == frix_pkg::CHAR_LF) begin
            at_line_start_next    = 1'b1;
            residue_run_open_next = 1'b0;
          end else if (run_open_eff && run_byte) begin
            residue_run_open_next = 1'b1;
            residues_counted_next = frix_pkg::sat_inc32(residues_counted);
            letters_seen_next     = letters_seen | letter_bit;
            if (countdown_dec == 32'd0) begin
              bench_total_next     = frix_pkg::sat_inc32(bench_total);
              bench_countdown_next = cfg.bench_interval;
              push0                = 1'b1;
              res0.kind            = frix_pkg::KIND_BENCH;
              res0.seq_number      = record_total - 32'd1;
              res0.last            = 1'b1;
              off0                 = OFFSET_BITS'(dist_inc);
            end else begin
              bench_countdown_next = countdown_dec;
            end
          end else begin
            residue_run_open_next = 1'b0;
          end
        end else begin
          // Text ahead of the first header only tracks line starts.
          at_line_start_next = (item_byte == frix_pkg::CHAR_LF);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      at_line_start     <= 1'b1;
      in_header         <= 1'b0;
      name_run_open     <= 1'b0;
      residue_run_open  <= 1'b0;
      residues_counted  <= '0;
      data_distance     <= '0;
      bench_countdown   <= '0;
      bench_total       <= '0;
      letters_seen      <= '0;
      record_total      <= '0;
      longest_name      <= '0;
      current_name_len  <= '0;
      alphabets_present <= '0;
    end else begin
      byte_position     <= byte_position_next;
      at_line_start     <= at_line_start_next;
      in_header         <= in_header_next;
      name_run_open     <= name_run_open_next;
      residue_run_open  <= residue_run_open_next;
      residues_counted  <= residues_counted_next;
      data_distance     <= data_distance_next;
      bench_countdown   <= bench_countdown_next;
      bench_total       <= bench_total_next;
      letters_seen      <= letters_seen_next;
      record_total      <= record_total_next;
      longest_name      <= longest_name_next;
      current_name_len  <= current_name_len_next;
      alphabets_present <= alphabets_present_next;
    end
  end

endmodule

// ----- hdl/frix_rq.sv -----
// ----------------------------------------------------------------------------
// frix_rq
// Result queue: takes up to two results a cycle while it has room, hands out one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module frix_rq #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] dout
);

  localparam int unsigned DEPTH = frix_pkg::RQ_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CW-1:0]    count;
  logic             pop;
  logic [CW-1:0]    count_next;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign dout       = entries[head];
  // Room is judged before this cycle's pop, so two pushes always fit.
  assign room       = (count <= CW'(DEPTH - 2));
  assign count_next = count + CW'(push0) + CW'(push1) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[tail] <= din0;
    end
    if (push1) begin
      entries[tail + PW'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PW'(pop);
      tail  <= tail + PW'(push0) + PW'(push1);
      count <= count_next;
    end
  end

endmodule

// ----- hdl/fasta_record_index_scanner.sv -----
// ----------------------------------------------------------------------------
// fasta_record_index_scanner
// Scans a FASTA byte stream and emits record, benchmark and summary events.
// ----------------------------------------------------------------------------
// Each accepted item (one file byte or an end-of-file mark) is scanned from
// the input register, so the block takes one item per clock while the output
// side keeps up; its results go through the result queue to the output port.
// A byte gives at most one event, an end-of-file mark gives a summary and, if
// a header line is still open, a record-start event ahead of it. Events wait
// in a four-entry queue, and input is held back only while an item waits in
// the input register and that queue has fewer than two free entries.
// The benchmark interval and forced alphabet registers are written over APB
// at byte addresses 0 and 4; the user must do so only while the block is
// idle, which the block itself does not enforce.
module fasta_record_index_scanner #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  frix_in_if.sink                            in_ch,
  frix_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [frix_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned RW = $bits(frix_pkg::result_t) + OFFSET_BITS;

  frix_pkg::cfg_t         cfg;
  logic                   rq_room;
  logic                   push0;
  logic                   push1;
  frix_pkg::result_t      res0;
  frix_pkg::result_t      res1;
  logic [OFFSET_BITS-1:0] off0;
  logic [OFFSET_BITS-1:0] off1;
  logic [RW-1:0]          rq_out;
  frix_pkg::result_t      head_res;
  logic [OFFSET_BITS-1:0] head_off;

  frix_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frix_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_ch.cmd),
    .in_byte  (in_ch.data_byte),
    .cfg      (cfg),
    .rq_room  (rq_room),
    .push0    (push0),
    .push1    (push1),
    .res0     (res0),
    .res1     (res1),
    .off0     (off0),
    .off1     (off1)
  );

  frix_rq #(
    .WIDTH (RW)
  ) u_rq (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .din0      ({res0, off0}),
    .din1      ({res1, off1}),
    .room      (rq_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (rq_out)
  );

  assign {head_res, head_off} = rq_out;

  assign out_ch.kind            = head_res.kind;
  assign out_ch.seq_number      = head_res.seq_number;
  assign out_ch.offset          = head_off;
  assign out_ch.record_length   = head_res.record_length;
  assign out_ch.name_length     = head_res.name_length;
  assign out_ch.alphabet        = head_res.alphabet;
  assign out_ch.benchmark_count = head_res.benchmark_count;
  assign out_ch.alphabet_flags  = head_res.alphabet_flags;
  assign out_ch.last            = head_res.last;

  // A second result only ever follows a first one in the same cycle.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0)
    else $error("second result pushed without a first");

  // Two results in one cycle are an open header's start event and the summary.
  a_pair_kinds: assert property (@(posedge clk) disable iff (rst)
    push1 |-> (res0.kind == frix_pkg::KIND_START) && !res0.last &&
              (res1.kind == frix_pkg::KIND_SUMMARY) && res1.last)
    else $error("unexpected result pair");

  // A lone result closes its item.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (push0 && !push1) |-> res0.last)
    else $error("single result without last");

  // Results are only pushed when the queue had room for them.
  a_room: assert property (@(posedge clk) disable iff (rst)
    push0 |-> rq_room)
    else $error("result pushed into a full queue");

endmodule

// ----- sim/frix_index_checker.sv -----
// ----------------------------------------------------------------------------
// FASTA index event checker
// Watches the byte and event channels and the register port of the scanner,
// keeps its own model of the scan state, and compares every event that
// leaves the block with the oldest one that the model still expects.
// ----------------------------------------------------------------------------
module frix_index_checker #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  frix_in_if                                 in_ch,
  frix_out_if                                out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [frix_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output int                                 errors,
  output int                                 pending,
  output int                                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 100;

  typedef struct packed {
    logic [1:0]             kind;
    logic [31:0]            seq_number;
    logic [OFFSET_BITS-1:0] offset;
    logic [31:0]            record_length;
    logic [15:0]            name_length;
    logic [1:0]             alphabet;
    logic [31:0]            benchmark_count;
    logic [2:0]             alphabet_flags;
    logic                   last;
  } index_event_t;

  index_event_t index_events[$];
  int err_count = 0;
  int n_checked = 0;

  logic [31:0] interval_reg;
  logic [1:0]  force_reg;

  // Scan state of the file being read.
  logic [OFFSET_BITS-1:0]            file_pos;
  logic                              line_start;
  logic                              in_hdr;
  logic                              name_open;
  logic                              run_open;
  logic [31:0]                       residues;
  logic [31:0]                       data_dist;
  logic [31:0]                       countdown;
  logic [31:0]                       benches;
  logic [frix_pkg::LETTER_COUNT-1:0] letters;
  logic [31:0]                       records;
  logic [15:0]                       longest;
  logic [15:0]                       hdr_name_bytes;
  logic [2:0]                        alpha_mask;

  function automatic logic [31:0] bump32(input logic [31:0] x);
    return (&x) ? x : x + 32'd1;
  endfunction

  function automatic logic in_run(input logic [7:0] b);
    return (b > frix_pkg::CHAR_SPACE) && (b < 8'h80);
  endfunction

  function automatic void clear_file();
    file_pos       = '0;
    line_start     = 1'b1;
    in_hdr         = 1'b0;
    name_open      = 1'b0;
    run_open       = 1'b0;
    residues       = '0;
    data_dist      = '0;
    countdown      = '0;
    benches        = '0;
    letters        = '0;
    records        = '0;
    longest        = '0;
    hdr_name_bytes = '0;
    alpha_mask     = '0;
  endfunction

  // Alphabet of the record being closed; it is also marked in the file flags.
  function automatic logic [1:0] close_alphabet();
    logic [1:0] a;
    if (force_reg != frix_pkg::FORCE_DETECT) begin
      a = force_reg - 2'd1;
    end else if ((letters & ~frix_pkg::NUC_LETTERS) == '0) begin
      a = letters[frix_pkg::LETTER_U] ? frix_pkg::ALPHA_RNA : frix_pkg::ALPHA_DNA;
    end else begin
      a = frix_pkg::ALPHA_PROTEIN;
    end
    alpha_mask[a] = 1'b1;
    return a;
  endfunction

  function automatic void push_event(input logic [1:0] kind, input logic [31:0] seq,
                                     input logic [OFFSET_BITS-1:0] off,
                                     input logic [31:0] len, input logic [15:0] nlen,
                                     input logic [1:0] alpha, input logic [31:0] bc,
                                     input logic [2:0] flags);
    index_event_t e;
    e.kind            = kind;
    e.seq_number      = seq;
    e.offset          = off;
    e.record_length   = len;
    e.name_length     = nlen;
    e.alphabet        = alpha;
    e.benchmark_count = bc;
    e.alphabet_flags  = flags;
    e.last            = 1'b0;
    index_events.push_back(e);
  endfunction

  function automatic void scan_item(input logic c, input logic [7:0] b);
    int         n;
    logic [1:0] a;
    logic [31:0] len;
    logic [31:0] bc;
    n = 0;
    if (c == frix_pkg::CMD_EOF) begin
      a   = frix_pkg::ALPHA_DNA;
      len = '0;
      bc  = '0;
      // A header line still open at end of file reports its start first.
      if (in_hdr) begin
        push_event(frix_pkg::KIND_START, records - 32'd1, file_pos, '0, hdr_name_bytes,
                   '0, '0, '0);
        n++;
      end
      if (records != 0) begin
        a   = close_alphabet();
        len = residues;
        bc  = benches;
      end
      push_event(frix_pkg::KIND_SUMMARY, records, file_pos, len, longest, a, bc,
                 alpha_mask);
      n++;
      clear_file();
    end else begin
      if (file_pos != '1) file_pos++;
      if (line_start && b == frix_pkg::CHAR_GT) begin
        if (records != 0) begin
          a = close_alphabet();
          push_event(frix_pkg::KIND_END, records - 32'd1, '0, residues, '0, a, benches,
                     '0);
          n++;
        end
        records        = bump32(records);
        in_hdr         = 1'b1;
        name_open      = 1'b1;
        hdr_name_bytes = '0;
        residues       = '0;
        data_dist      = '0;
        countdown      = interval_reg;
        benches        = '0;
        letters        = '0;
        line_start     = 1'b0;
      end else if (in_hdr) begin
        if (b == frix_pkg::CHAR_LF) begin
          in_hdr     = 1'b0;
          line_start = 1'b1;
          push_event(frix_pkg::KIND_START, records - 32'd1, file_pos, '0, hdr_name_bytes,
                     '0, '0, '0);
          n++;
        end else begin
          if (name_open && in_run(b)) begin
            if (hdr_name_bytes != 16'hFFFF) hdr_name_bytes++;
            if (hdr_name_bytes > longest) longest = hdr_name_bytes;
          end else begin
            name_open = 1'b0;
          end
          line_start = 1'b0;
        end
      end else if (records != 0) begin
        if (line_start) run_open = 1'b1;
        line_start = 1'b0;
        data_dist  = bump32(data_dist);
        if (b == frix_pkg::CHAR_LF) begin
          line_start = 1'b1;
          run_open   = 1'b0;
        end else if (run_open && in_run(b)) begin
          residues = bump32(residues);
          if (b >= frix_pkg::CHAR_UPPER_A && b <= frix_pkg::CHAR_UPPER_Z) begin
            letters[b - frix_pkg::CHAR_UPPER_A] = 1'b1;
          end else if (b >= frix_pkg::CHAR_LOWER_A && b <= frix_pkg::CHAR_LOWER_Z) begin
            letters[b - frix_pkg::CHAR_LOWER_A] = 1'b1;
          end
          // A zero interval simply wraps the countdown.
          countdown = countdown - 32'd1;
          if (countdown == '0) begin
            benches   = bump32(benches);
            countdown = interval_reg;
            push_event(frix_pkg::KIND_BENCH, records - 32'd1, OFFSET_BITS'(data_dist), '0,
                       '0, '0, '0, '0);
            n++;
          end
        end else begin
          run_open = 1'b0;
        end
      end else begin
        line_start = (b == frix_pkg::CHAR_LF);
      end
    end
    if (n > 0) index_events[index_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  function automatic void compare_result();
    index_event_t want;
    if (index_events.size() == 0) begin
      err_count++;
      if (err_count <= REPORT_LIMIT) begin
        $display("%0t: event with none expected, expected nothing, actual kind %0d seq %0d",
                 $time, out_ch.kind, out_ch.seq_number);
      end
    end else begin
      want = index_events.pop_front();
      n_checked++;
      check_field("kind", want.kind, out_ch.kind);
      check_field("seq_number", want.seq_number, out_ch.seq_number);
      check_field("offset", want.offset, out_ch.offset);
      check_field("record_length", want.record_length, out_ch.record_length);
      check_field("name_length", want.name_length, out_ch.name_length);
      check_field("alphabet", want.alphabet, out_ch.alphabet);
      check_field("benchmark_count", want.benchmark_count, out_ch.benchmark_count);
      check_field("alphabet_flags", want.alphabet_flags, out_ch.alphabet_flags);
      check_field("last", want.last, out_ch.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      interval_reg = frix_pkg::BENCH_INTERVAL_RESET;
      force_reg    = frix_pkg::FORCE_DETECT;
      clear_file();
      index_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[frix_pkg::REG_ADDR_BITS-1:2] == frix_pkg::REG_BENCH_INTERVAL) begin
          interval_reg = pwdata;
        end else if (paddr[frix_pkg::REG_ADDR_BITS-1:2] == frix_pkg::REG_FORCED_ALPHABET)
        begin
          force_reg = pwdata[1:0];
        end
      end
      if (in_ch.valid && in_ch.ready) scan_item(in_ch.cmd, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) compare_result();
    end
    errors  <= err_count;
    pending <= index_events.size();
    checked <= n_checked;
  end

endmodule

// ----- sim/tb_fasta_record_index_scanner.sv -----
// ----------------------------------------------------------------------------
// FASTA record index scanner testbench
// Feeds the scanner short FASTA files, both hand-made and random, under a
// series of benchmark intervals and forced alphabets, with random idle
// cycles on both channels and one long output back-up. The checker beside
// the block predicts every index event and reports the failures.
// ----------------------------------------------------------------------------
module tb_fasta_record_index_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFFSET_BITS     = 48;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned PRESSURE_PHASE  = 1;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned LONG_HOLD       = 80;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned IDLE_LIMIT      = 1000;

  localparam logic [1:0] FORCE_DNA     = 2'd1;
  localparam logic [1:0] FORCE_RNA     = 2'd2;
  localparam logic [1:0] FORCE_PROTEIN = 2'd3;

  localparam logic [frix_pkg::REG_ADDR_BITS-1:0] ADDR_BENCH =
    {frix_pkg::REG_BENCH_INTERVAL, 2'b00};
  localparam logic [frix_pkg::REG_ADDR_BITS-1:0] ADDR_FORCE =
    {frix_pkg::REG_FORCED_ALPHABET, 2'b00};

  localparam logic [31:0] PHASE_INTERVAL [N_PHASES] =
    '{32'd2, 32'd1, 32'd5, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd4, 32'd1000};
  localparam logic [1:0] PHASE_FORCE [N_PHASES] =
    '{frix_pkg::FORCE_DETECT, frix_pkg::FORCE_DETECT, FORCE_DNA, FORCE_RNA, FORCE_PROTEIN,
      frix_pkg::FORCE_DETECT, frix_pkg::FORCE_DETECT, frix_pkg::FORCE_DETECT};

  typedef enum int {FLAVOR_DNA, FLAVOR_RNA, FLAVOR_PROTEIN, FLAVOR_MIXED} flavor_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [frix_pkg::REG_ADDR_BITS-1:0] paddr;
  logic [31:0]                        pwdata;
  logic [31:0]                        prdata;
  logic                               pready;
  logic                               long_hold_req;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int files_sent = 0;
  bit steady = 1'b0;

  string dna_chars = "ACGTNacgtn";
  string rna_chars = "ACGUNacgu";
  string odd_chars = "*-.0123xX";

  frix_in_if in_ch ();
  frix_out_if #(.OFFSET_BITS(OFFSET_BITS)) out_ch ();

  fasta_record_index_scanner #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  frix_index_checker #(.OFFSET_BITS(OFFSET_BITS)) u_index_check (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .pready (pready),
    .paddr  (paddr),
    .pwdata (pwdata),
    .errors (fail_count),
    .pending(pending),
    .checked(checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Event receiver: short random stalls, calm stretches, and one long hold
  // that backs the block up while the sender keeps offering bytes.
  int hold_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  int pick;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          stall_left = $urandom_range(1, 3);
        end else if (pick < 17) begin
          stall_left = $urandom_range(10, 30);
        end else if (pick == 17) begin
          calm_left = $urandom_range(50, 200);
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d events outstanding",
               $time, idle_cycles, pending);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] b);
    int gap;
    int r;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    r = $urandom_range(0, 99);
    if (steady || r < 70) begin
      gap = 0;
    end else if (r < 95) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(frix_pkg::CMD_BYTE, b);
  endtask

  task automatic send_eof();
    send_item(frix_pkg::CMD_EOF, 8'($urandom_range(0, 255)));
    files_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering and let every expected event come out before going on.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frix_pkg::REG_ADDR_BITS-1:0] addr,
                           input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] noise_no_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == frix_pkg::CHAR_LF) ? 8'h80 : b;
  endfunction

  function automatic logic [7:0] residue_char(input flavor_t flavor);
    logic [7:0] c;
    case (flavor)
      FLAVOR_DNA: begin
        c = dna_chars[$urandom_range(0, dna_chars.len() - 1)];
      end
      FLAVOR_RNA: begin
        c = rna_chars[$urandom_range(0, rna_chars.len() - 1)];
      end
      FLAVOR_PROTEIN: begin
        c = ($urandom_range(0, 1) == 0) ?
            frix_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25)) :
            frix_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
      end
      default: begin
        c = odd_chars[$urandom_range(0, odd_chars.len() - 1)];
      end
    endcase
    return c;
  endfunction

  // One random file: optional text before the first header, a few records
  // with names, descriptions and data lines, some stray bytes, then end of file.
  task automatic send_file();
    int      recs;
    int      lines;
    int      k;
    int      j;
    bit      open_end;
    flavor_t flavor;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(noise_no_lf());
      send_byte(frix_pkg::CHAR_LF);
    end
    recs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (k = 0; k < recs; k++) begin
      flavor = flavor_t'($urandom_range(0, 3));
      send_byte(frix_pkg::CHAR_GT);
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(33, 127)));
      if ($urandom_range(0, 2) == 0) begin
        send_byte(frix_pkg::CHAR_SPACE);
        repeat ($urandom_range(1, 4)) send_byte(noise_no_lf());
      end
      open_end = (k == recs - 1) && ($urandom_range(0, 7) == 0);
      if (!open_end) begin
        send_byte(frix_pkg::CHAR_LF);
        lines = $urandom_range(0, 3);
        for (j = 0; j < lines; j++) begin
          repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 19) == 0) begin
              send_byte(8'($urandom_range(0, 255)));
            end else begin
              send_byte(residue_char(flavor));
            end
          end
          if ($urandom_range(0, 4) == 0) begin
            send_byte(frix_pkg::CHAR_SPACE);
            send_byte(8'($urandom_range(0, 255)));
          end
          // An unterminated last line lets the next '>' land mid-line.
          if (j < lines - 1 || $urandom_range(0, 5) != 0) send_byte(frix_pkg::CHAR_LF);
        end
      end
    end
    send_eof();
  endtask

  initial begin
    int p;
    int target;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= frix_pkg::CMD_BYTE;
    in_ch.data_byte <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    long_hold_req   <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One file under the reset register values.
    send_file();

    for (p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_reg(ADDR_BENCH, PHASE_INTERVAL[p]);
      write_reg(ADDR_FORCE, 32'(PHASE_FORCE[p]));
      @(posedge clk);
      if (p == 0) begin
        // Text before the header, a DEL in the name, an RNA record whose
        // residue run is cut by a control byte, a name cut by a high byte,
        // a header still open at end of file, and an empty file.
        send_text("Z\n>");
        send_byte(8'h7F);
        send_text("a b\nacgu");
        send_byte(8'h01);
        send_text("t\n>");
        send_byte(8'hC8);
        send_text("q");
        send_eof();
        send_eof();
      end
      steady = (p == PRESSURE_PHASE);
      if (steady) long_hold_req <= 1'b1;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        send_file();
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
      steady = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Scanned %0d items in %0d files under %0d register settings,",
             items_sent, files_sent, N_PHASES + 1);
    $display("with %0d index events compared, one long output back-up included.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
